### hw/rtl/mbe_pkg.sv
package mbe_pkg;

   localparam int PIX_W     = 12;
   localparam int PIX_EXT_W = 16;
   localparam int SIZE_W    = 13;
   localparam int CENTER_W  = 36;
   localparam int STEP_W    = 35;
   localparam int LIMIT_W   = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 36;

   // 2*pixel - size spans [-8191, 8190]
   localparam int OFF_W   = 14;
   localparam int PROD_W  = OFF_W + STEP_W + 1;
   localparam int TWICE_W = PROD_W;
   localparam int C_W     = TWICE_W - 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CENTER_RE = 3'd0,
      CSR_CENTER_IM = 3'd1,
      CSR_STEP      = 3'd2,
      CSR_LIMIT     = 3'd3,
      CSR_WIDTH     = 3'd4,
      CSR_HEIGHT    = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [CENTER_W-1:0] center_re;
      logic [CENTER_W-1:0] center_im;
      logic [STEP_W-1:0]   step_scale;
      logic [LIMIT_W-1:0]  iteration_limit;
      logic [SIZE_W-1:0]   view_cols;
      logic [SIZE_W-1:0]   view_rows;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      center_re:       -36'sd2735951066,
      center_im:       -36'sd169716736,
      step_scale:      35'd8589935,
      iteration_limit: 16'd1024,
      view_cols:       13'd1920,
      view_rows:       13'd1080
   };

   typedef struct packed {
      logic start;
      logic map_mul;
      logic map_add;
      logic mul;
      logic sum;
      logic upd;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic lim_zero;
      logic radius_esc;
      logic bound_esc;
      logic count_hit;
   } status_type;

endpackage

### hw/rtl/mbe_ctrl.sv
module mbe_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  mbe_pkg::status_type status,
   output mbe_pkg::cmd_type    cmd
);
   import mbe_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAP_MUL,
      ST_MAP_ADD,
      ST_MUL,
      ST_SUM,
      ST_UPD,
      ST_DONE
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      out_free;

   always_comb begin
      req_ready    = (state_ff == ST_IDLE);
      out_free     = !rsp_valid_ff || rsp_ready;
      cmd          = '0;
      cmd.start    = req_valid && req_ready;
      cmd.map_mul  = (state_ff == ST_MAP_MUL);
      cmd.map_add  = (state_ff == ST_MAP_ADD);
      cmd.mul      = (state_ff == ST_MUL);
      cmd.sum      = (state_ff == ST_SUM);
      cmd.upd      = (state_ff == ST_UPD) && !status.radius_esc;
      cmd.load_out = (state_ff == ST_DONE) && out_free;
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (cmd.start) begin
                  state_ff <= status.lim_zero ? ST_DONE : ST_MAP_MUL;
               end
            end
            ST_MAP_MUL: begin
               state_ff <= ST_MAP_ADD;
            end
            ST_MAP_ADD: begin
               state_ff <= ST_MUL;
            end
            ST_MUL: begin
               state_ff <= ST_SUM;
            end
            ST_SUM: begin
               state_ff <= ST_UPD;
            end
            ST_UPD: begin
               if (status.radius_esc || status.bound_esc || status.count_hit) begin
                  state_ff <= ST_DONE;
               end else begin
                  state_ff <= ST_MUL;
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

### hw/rtl/mbe_dp.sv
module mbe_dp #(
   parameter int FRAC_BITS  = 32,
   parameter int COUNT_BITS = 16,
   parameter int PIXEL_BITS = 12
) (
   input  logic                              clock,
   input  mbe_pkg::cfg_type                  cfg,
   input  mbe_pkg::cmd_type                  cmd,
   output mbe_pkg::status_type               status,
   input  logic [mbe_pkg::PIX_W-1:0]         req_pixel_x,
   input  logic [mbe_pkg::PIX_W-1:0]         req_pixel_y,
   output logic [mbe_pkg::LIMIT_W-1:0]       rsp_iteration_count,
   output logic                              rsp_inside_set
);
   import mbe_pkg::*;

   localparam int MW   = FRAC_BITS + 2;
   localparam int H    = (MW + 1) / 2;
   localparam int HB   = MW - H;
   localparam int PW   = 2 * MW;
   localparam int SQ_W = PW - FRAC_BITS;
   localparam int IQ_W = PW + 1 - FRAC_BITS;
   localparam int ZW   = ((FRAC_BITS + 4 > C_W) ? FRAC_BITS + 4 : C_W) + 2;

   localparam logic [COUNT_BITS-1:0] CMAX    = '1;
   localparam logic [PW:0]           FOUR_SQ = (PW + 1)'(1) << (2 * FRAC_BITS + 2);
   localparam logic signed [ZW-1:0]  TWO     = ZW'(1) << (FRAC_BITS + 1);
   localparam logic signed [ZW-1:0]  NEG_TWO = -TWO;

   // mapping
   logic [PIX_EXT_W-1:0]      px_ext, py_ext;
   logic [PIX_W-1:0]          px, py;
   logic signed [OFF_W-1:0]   off_x_ff, off_y_ff;
   logic signed [PROD_W-1:0]  prod_x_ff, prod_y_ff;
   logic signed [TWICE_W-1:0] twice_x, twice_y;
   logic signed [C_W-1:0]     c_re_ff, c_im_ff;

   // iteration
   logic signed [ZW-1:0]      re_ff, im_ff, re_in, im_in;
   logic [ZW-1:0]             re_abs, im_abs, qx;
   logic [MW-1:0]             re_mag, im_mag;
   logic [HB-1:0]             ah, bh;
   logic [H-1:0]              al, bl;
   logic [2*HB-1:0]           rr_hh_ff, ii_hh_ff, ri_hh_ff;
   logic [HB+H-1:0]           rr_hl_ff, ii_hl_ff, ri_hl_ff, ri_lh_ff;
   logic [2*H-1:0]            rr_ll_ff, ii_ll_ff, ri_ll_ff;
   logic                      neg_ff;
   logic [PW-1:0]             rr_ff, ii_ff, ri_ff;
   logic [PW:0]               sum_sq, p2;
   logic [SQ_W-1:0]           rr_sh, ii_sh;
   logic [IQ_W-1:0]           q;
   logic                      rem;

   logic [COUNT_BITS-1:0]     lim_eff, count_ff, count_in;
   logic [LIMIT_W-1:0]        out_count_ff;
   logic                      out_inside_ff;

   always_comb begin
      px_ext  = PIX_EXT_W'(req_pixel_x);
      py_ext  = PIX_EXT_W'(req_pixel_y);
      px      = PIX_W'(px_ext[PIXEL_BITS-1:0]);
      py      = PIX_W'(py_ext[PIXEL_BITS-1:0]);
      twice_x = $signed(prod_x_ff) + TWICE_W'($signed({cfg.center_re, 1'b0}));
      twice_y = $signed(prod_y_ff) + TWICE_W'($signed({cfg.center_im, 1'b0}));
      if (cfg.iteration_limit > LIMIT_W'(CMAX)) begin
         lim_eff = CMAX;
      end else begin
         lim_eff = cfg.iteration_limit[COUNT_BITS-1:0];
      end
   end

   always_comb begin
      re_abs = re_ff[ZW-1] ? -re_ff : re_ff;
      im_abs = im_ff[ZW-1] ? -im_ff : im_ff;
      re_mag = re_abs[MW-1:0];
      im_mag = im_abs[MW-1:0];
      ah     = re_mag[MW-1:H];
      al     = re_mag[H-1:0];
      bh     = im_mag[MW-1:H];
      bl     = im_mag[H-1:0];
   end

   always_comb begin
      sum_sq   = (PW + 1)'(rr_ff) + (PW + 1)'(ii_ff);
      rr_sh    = rr_ff[PW-1:FRAC_BITS];
      ii_sh    = ii_ff[PW-1:FRAC_BITS];
      re_in    = ZW'($signed({1'b0, rr_sh})) - ZW'($signed({1'b0, ii_sh}))
                 + ZW'(c_re_ff);
      p2       = {ri_ff, 1'b0};
      q        = p2[PW:FRAC_BITS];
      rem      = |p2[FRAC_BITS-1:0];
      qx       = ZW'(q);
      // floor of a negative product: -(q + rem) = ~q + !rem
      im_in    = $signed(ZW'(c_im_ff) + (neg_ff ? ~qx : qx) + ZW'(neg_ff && !rem));
      count_in = count_ff + COUNT_BITS'(1);

      status.lim_zero   = (lim_eff == '0);
      status.radius_esc = (sum_sq > FOUR_SQ);
      status.bound_esc  = (re_in > TWO) || (re_in < NEG_TWO)
                          || (im_in > TWO) || (im_in < NEG_TWO);
      status.count_hit  = (count_in == lim_eff);
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         off_x_ff <= $signed({1'b0, px, 1'b0}) - $signed({1'b0, cfg.view_cols});
         off_y_ff <= $signed({1'b0, py, 1'b0}) - $signed({1'b0, cfg.view_rows});
         re_ff    <= '0;
         im_ff    <= '0;
         count_ff <= '0;
      end
      if (cmd.map_mul) begin
         prod_x_ff <= off_x_ff * $signed({1'b0, cfg.step_scale});
         prod_y_ff <= off_y_ff * $signed({1'b0, cfg.step_scale});
      end
      if (cmd.map_add) begin
         c_re_ff <= twice_x[TWICE_W-1:1];
         c_im_ff <= twice_y[TWICE_W-1:1];
      end
      if (cmd.mul) begin
         rr_hh_ff <= ah * ah;
         rr_hl_ff <= ah * al;
         rr_ll_ff <= al * al;
         ii_hh_ff <= bh * bh;
         ii_hl_ff <= bh * bl;
         ii_ll_ff <= bl * bl;
         ri_hh_ff <= ah * bh;
         ri_hl_ff <= ah * bl;
         ri_lh_ff <= al * bh;
         ri_ll_ff <= al * bl;
         neg_ff   <= re_ff[ZW-1] ^ im_ff[ZW-1];
      end
      if (cmd.sum) begin
         rr_ff <= (PW'(rr_hh_ff) << (2 * H)) + (PW'(rr_hl_ff) << (H + 1)) + PW'(rr_ll_ff);
         ii_ff <= (PW'(ii_hh_ff) << (2 * H)) + (PW'(ii_hl_ff) << (H + 1)) + PW'(ii_ll_ff);
         ri_ff <= (PW'(ri_hh_ff) << (2 * H)) + (PW'(ri_hl_ff) << H)
                  + (PW'(ri_lh_ff) << H) + PW'(ri_ll_ff);
      end
      if (cmd.upd) begin
         re_ff    <= re_in;
         im_ff    <= im_in;
         count_ff <= count_in;
      end
      if (cmd.load_out) begin
         out_count_ff  <= LIMIT_W'(count_ff);
         out_inside_ff <= (count_ff == lim_eff);
      end
   end

   assign rsp_iteration_count = out_count_ff;
   assign rsp_inside_set      = out_inside_ff;

endmodule

### hw/rtl/mandelbrot_escape_time_unit.sv
// Escape-time evaluator for one pixel of a Mandelbrot view.
// req channel: one beat carries pixel_x / pixel_y. The pixel is mapped to
// c = center + (pixel - size/2) * step, then z = z^2 + c runs from z = 0
// until |z|^2 > 4 or the count reaches iteration_limit.
// rsp channel: one beat per request with iteration_count and inside_set
// (set when the count equals the limit; a zero limit gives count 0, inside).
// csr port: write-only, csr_index selects center_re, center_im, step_scale,
// iteration_limit, view width, view height; write only while idle.
// One pixel at a time. Mapping runs a multiply step, then an add step;
// each iteration runs partial products, product sum, then update with
// escape test. A zero limit goes straight to the result without
// iterating. The next request is accepted in the cycle after the result
// loads. The default iteration limit is 1024.
// The result sits in an output register: the next request is accepted while
// a result still waits; a stalled receiver holds that beat and a finished
// pixel behind it waits until the register frees.
// Reset returns the control to idle, drops rsp_valid and loads the default
// view registers.
module mandelbrot_escape_time_unit #(
   parameter int FRAC_BITS  = 32,
   parameter int COUNT_BITS = 16,
   parameter int PIXEL_BITS = 12
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [mbe_pkg::PIX_W-1:0]          req_pixel_x,
   input  logic [mbe_pkg::PIX_W-1:0]          req_pixel_y,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [mbe_pkg::LIMIT_W-1:0]        rsp_iteration_count,
   output logic                               rsp_inside_set,
   input  logic                               csr_wr_en,
   input  logic [mbe_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mbe_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import mbe_pkg::*;

   cfg_type    cfg_ff;
   cmd_type    cmd;
   status_type status;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_CENTER_RE: cfg_ff.center_re       <= csr_wdata[CENTER_W-1:0];
            CSR_CENTER_IM: cfg_ff.center_im       <= csr_wdata[CENTER_W-1:0];
            CSR_STEP:      cfg_ff.step_scale      <= csr_wdata[STEP_W-1:0];
            CSR_LIMIT:     cfg_ff.iteration_limit <= csr_wdata[LIMIT_W-1:0];
            CSR_WIDTH:     cfg_ff.view_cols       <= csr_wdata[SIZE_W-1:0];
            CSR_HEIGHT:    cfg_ff.view_rows       <= csr_wdata[SIZE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   mbe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mbe_dp #(
      .FRAC_BITS  (FRAC_BITS),
      .COUNT_BITS (COUNT_BITS),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_dp (
      .clock               (clock),
      .cfg                 (cfg_ff),
      .cmd                 (cmd),
      .status              (status),
      .req_pixel_x         (req_pixel_x),
      .req_pixel_y         (req_pixel_y),
      .rsp_iteration_count (rsp_iteration_count),
      .rsp_inside_set      (rsp_inside_set)
   );

endmodule
